// ===== design/bwtf_pkg.sv =====
// Shared types and constants for the forward Burrows-Wheeler transform block.
package bwtf_pkg;

  localparam int BLOCK_SIZE = 256;
  localparam int ADDR_W     = $clog2(BLOCK_SIZE);
  localparam int LEN_W      = ADDR_W + 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_in;
    logic       end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] primary_index;
    logic       last;
    logic       no_data;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
  } store_req_t;

endpackage

// ===== design/bwtf_store.sv =====
// Block byte store: one write port and two registered read ports.
module bwtf_store import bwtf_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rd_a,
  output logic [7:0] rd_b
);

  logic [7:0] mem [BLOCK_SIZE];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_a <= mem[req.rd_addr_a];
    rd_b <= mem[req.rd_addr_b];
  end

endmodule

// ===== design/bwt_forward_block.sv =====
// Top level of the forward Burrows-Wheeler transform block.
//
// Load requests write one byte each into the block store, one per cycle while idle;
// bytes past 256 are dropped and the overflow flag is set. The load request marked end
// of block starts the sort, during which no request is taken. Each rotation i is ranked
// by comparing it with every other rotation j, one byte pair at a time through the two
// read ports of the block store (a read state, then a compare state), stopping at the
// first differing byte; the index i is written to the sorted-row memory at its rank.
// The primary index is the rank of the unrotated block. A drain request passes through
// the sorted-row read, the store read, the result staging register and the output
// register, which holds a result while the next request is taken. A drain with no
// finished block returns a result with no_data set.
module bwt_forward_block import bwtf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAIR, S_RD, S_CMP, S_WR, S_DROW, S_DBYTE, S_OUT
  } state_t;

  state_t            state;
  logic              ready;
  logic [LEN_W-1:0]  block_len;
  logic [LEN_W-1:0]  drain_ptr;
  logic [ADDR_W-1:0] primary;
  logic              ovf;
  logic [ADDR_W-1:0] ri;
  logic [ADDR_W-1:0] rj;
  logic [LEN_W-1:0]  k;
  logic [ADDR_W-1:0] pa;
  logic [ADDR_W-1:0] pb;
  logic [ADDR_W-1:0] rank;
  out_item_t         res;

  logic [ADDR_W-1:0] sorted_mem [BLOCK_SIZE];
  logic [ADDR_W-1:0] srow;

  store_req_t        sreq;
  logic [7:0]        rd_a;
  logic [7:0]        rd_b;

  logic              in_acc;
  logic [LEN_W-1:0]  load_len;
  logic [ADDR_W-1:0] last_idx;
  logic [ADDR_W-1:0] pos;
  logic              out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign last_idx = block_len[ADDR_W-1:0] - ADDR_W'(1);

  // A load after a finished block starts a new, empty one.
  assign load_len = ready ? '0 : block_len;

  // Last column byte of a row is the one just before its rotation start.
  assign pos = (srow == '0) ? last_idx : srow - ADDR_W'(1);

  always_comb begin
    sreq.wr_en     = in_acc && (in_item.cmd == CMD_LOAD) && (load_len < LEN_W'(BLOCK_SIZE));
    sreq.wr_addr   = load_len[ADDR_W-1:0];
    sreq.wr_data   = in_item.byte_in;
    sreq.rd_addr_a = (state == S_DROW) ? pos : pa;
    sreq.rd_addr_b = pb;
  end

  bwtf_store u_store (
    .clk  (clk),
    .req  (sreq),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // Sorted-row memory: written with each rotation's index at its rank, read at the drain pointer.
  always_ff @(posedge clk) begin
    if (state == S_WR) begin
      sorted_mem[rank] <= ri;
    end
    srow <= sorted_mem[drain_ptr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= 1'b0;
      block_len <= '0;
      drain_ptr <= '0;
      primary   <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The result register empties when taken, unless a new result moves in.
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && in_item.cmd == CMD_LOAD) begin
            ready     <= 1'b0;
            drain_ptr <= '0;
            if (load_len < LEN_W'(BLOCK_SIZE)) begin
              block_len <= load_len + LEN_W'(1);
              ovf       <= ready ? 1'b0 : ovf;
            end else begin
              block_len <= load_len;
              ovf       <= 1'b1;
            end
            // Every load leaves at least one byte, so end of block always sorts.
            if (in_item.end_of_block) begin
              ri    <= '0;
              rj    <= '0;
              rank  <= '0;
              state <= S_PAIR;
            end
          end else if (in_acc) begin
            if (!ready || drain_ptr >= block_len) begin
              res.out_byte      <= '0;
              res.primary_index <= '0;
              res.last          <= 1'b0;
              res.no_data       <= 1'b1;
              res.overflow      <= ovf;
              state             <= S_OUT;
            end else begin
              state <= S_DROW;
            end
          end
        end
        S_PAIR: begin
          if (rj == ri) begin
            if ({1'b0, rj} + LEN_W'(1) == block_len) begin
              state <= S_WR;
            end else begin
              rj <= rj + ADDR_W'(1);
            end
          end else begin
            pa    <= rj;
            pb    <= ri;
            k     <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_a != rd_b || k + LEN_W'(1) == block_len) begin
            // Rotation j ranks before i if smaller, or equal and earlier.
            if (rd_a < rd_b || (rd_a == rd_b && rj < ri)) begin
              rank <= rank + ADDR_W'(1);
            end
            if ({1'b0, rj} + LEN_W'(1) == block_len) begin
              state <= S_WR;
            end else begin
              rj    <= rj + ADDR_W'(1);
              state <= S_PAIR;
            end
          end else begin
            pa    <= (pa == last_idx) ? '0 : pa + ADDR_W'(1);
            pb    <= (pb == last_idx) ? '0 : pb + ADDR_W'(1);
            k     <= k + LEN_W'(1);
            state <= S_RD;
          end
        end
        S_WR: begin
          if (ri == '0) begin
            primary <= rank;
          end
          if ({1'b0, ri} + LEN_W'(1) == block_len) begin
            ready <= 1'b1;
            state <= S_IDLE;
          end else begin
            ri    <= ri + ADDR_W'(1);
            rj    <= '0;
            rank  <= '0;
            state <= S_PAIR;
          end
        end
        S_DROW: begin
          state <= S_DBYTE;
        end
        S_DBYTE: begin
          res.out_byte      <= rd_a;
          res.primary_index <= primary;
          res.no_data       <= 1'b0;
          res.overflow      <= ovf;
          if (drain_ptr + LEN_W'(1) == block_len) begin
            res.last  <= 1'b1;
            ready     <= 1'b0;
            block_len <= '0;
            drain_ptr <= '0;
            ovf       <= 1'b0;
          end else begin
            res.last  <= 1'b0;
            drain_ptr <= drain_ptr + LEN_W'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cmp_in_block: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> k < block_len) else $error("byte compare ran past block end");
  a_ready_nonempty: assert property (@(posedge clk) disable iff (rst)
    ready |-> block_len != '0) else $error("finished block is empty");
  a_rank_in_block: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> {1'b0, rank} < block_len) else $error("rank beyond block length");
  a_eob_starts_sort: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.cmd == CMD_LOAD && in_item.end_of_block |=> state == S_PAIR)
    else $error("end of block did not start the sort");
`endif

endmodule
